FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL, sampled on the rising edge of i_clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/ifp_pkg.sv
package ifp_pkg;

    // default operator stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // ASCII characters with a meaning of their own
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // stacked operator codes
    typedef enum logic [2:0] {
        CODE_ADD  = 3'd0,
        CODE_SUB  = 3'd1,
        CODE_MUL  = 3'd2,
        CODE_DIV  = 3'd3,
        CODE_OPEN = 3'd4
    } t_code;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK              = 2'd0,
        ST_OVERFLOW        = 2'd1,
        ST_UNMATCHED_CLOSE = 2'd2,
        ST_UNMATCHED_OPEN  = 2'd3
    } t_status;

    // stack commands from the sequencer
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        t_code code;
    } t_stack_ctrl;

    // character for a stacked operator
    function automatic logic [7:0] code_char(input t_code code);
        logic [7:0] ch;
        case (code)
            CODE_ADD: ch = CH_PLUS;
            CODE_SUB: ch = CH_MINUS;
            CODE_MUL: ch = CH_STAR;
            CODE_DIV: ch = CH_SLASH;
            default:  ch = CH_OPEN;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/ifp_if.sv
// input channel: one expression character per item
interface ifp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_expression;

    modport source (output valid, output in_char, output end_of_expression, input ready);
    modport sink   (input valid, input in_char, input end_of_expression, output ready);
endinterface

// output channel: one postfix character or status per item
interface ifp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, output out_char, output char_valid, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input char_valid, input status,
                    input last_of_run, output ready);
endinterface

FILE: rtl/ifp_op_stack.sv
module ifp_op_stack #(
    parameter int DEPTH = ifp_pkg::STACK_DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ifp_pkg::t_stack_ctrl i_ctrl,
    output ifp_pkg::t_code      o_top,
    output logic [CNT_W-1:0]    o_count
);
    import ifp_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_code            r_stack [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] top_pos;

    // top entry sits one below the count
    assign top_pos = r_count - CNT_W'(1);
    assign o_top   = r_stack[top_pos[IDX_W-1:0]];
    assign o_count = r_count;

    // fill count, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
        end else if (i_ctrl.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_ctrl.pop) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // entries, written at a push without clear; the sequencer pushes only below full
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !i_ctrl.clear) begin
            r_stack[r_count[IDX_W-1:0]] <= i_ctrl.code;
        end
    end

endmodule

FILE: rtl/infix_to_postfix_converter.sv
// Shunting-yard infix to postfix converter, one character per input item.
// An operand's result passes the pending slot and then the output register on its way out.
// A new character is accepted only in the idle state, once the previous one is finished;
// output stalls hold the sequencer, which otherwise takes one pop/compare step per cycle.
// Reset clears the stack count and the output side; stack entries are not cleared.
`include "assert_macros.svh"

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifp_in_if.sink    i_in,
    ifp_out_if.source o_out
);
    import ifp_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_POP    = 5'b00010,
        S_PUSH   = 5'b00100,
        S_FLUSH  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // how far the pop phase runs
    typedef enum logic [1:0] {
        MODE_LOW   = 2'd0,
        MODE_HIGH  = 2'd1,
        MODE_CLOSE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        t_status    status;
    } t_result;

    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    t_code       r_code, n_code;
    logic        r_eoe, n_eoe;
    t_result     r_pend;
    logic        r_pend_v;
    t_result     r_out;
    logic        r_out_last;
    logic        r_out_v;

    t_stack_ctrl ctrl;
    t_code       top;
    logic [CNT_W-1:0] count;
    logic        slot_free;
    logic        emit;
    t_result     emit_res;
    logic        final_step;
    logic        load_out;
    logic        top_pops;
    logic        after_eoe;

    ifp_op_stack #(
        .DEPTH (STACK_DEPTH),
        .CNT_W (CNT_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_top   (top),
        .o_count (count)
    );

    assign slot_free = !r_out_v || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // top may be popped in the current mode
    assign top_pops = (count != '0) && (top != CODE_OPEN) &&
                      !((r_mode == MODE_HIGH) && ((top == CODE_ADD) || (top == CODE_SUB)));

    // sequencer: one stack step per cycle while the output slot is free
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_code     = r_code;
        n_eoe      = r_eoe;
        ctrl       = '0;
        ctrl.code  = r_code;
        emit       = 1'b0;
        emit_res   = '0;
        final_step = 1'b0;
        after_eoe  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_eoe  = i_in.end_of_expression;
                    n_mode = MODE_LOW;
                    n_code = CODE_ADD;
                    case (i_in.in_char)
                        CH_PLUS: begin
                            n_state = S_POP;
                        end
                        CH_MINUS: begin
                            n_code  = CODE_SUB;
                            n_state = S_POP;
                        end
                        CH_STAR: begin
                            n_mode  = MODE_HIGH;
                            n_code  = CODE_MUL;
                            n_state = S_POP;
                        end
                        CH_SLASH: begin
                            n_mode  = MODE_HIGH;
                            n_code  = CODE_DIV;
                            n_state = S_POP;
                        end
                        CH_OPEN: begin
                            n_code  = CODE_OPEN;
                            n_state = S_PUSH;
                        end
                        CH_CLOSE: begin
                            n_mode  = MODE_CLOSE;
                            n_state = S_POP;
                        end
                        default: begin
                            // operand passes straight through
                            emit        = 1'b1;
                            emit_res.ch = i_in.in_char;
                            emit_res.cv = 1'b1;
                            n_state     = i_in.end_of_expression ? S_FLUSH : S_FINISH;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (slot_free) begin
                    if (top_pops) begin
                        emit        = 1'b1;
                        emit_res.ch = code_char(top);
                        emit_res.cv = 1'b1;
                        ctrl.pop    = 1'b1;
                    end else if (r_mode == MODE_CLOSE) begin
                        // drop the matching open paren, or flag its absence
                        if (count != '0) begin
                            ctrl.pop = 1'b1;
                        end else begin
                            emit            = 1'b1;
                            emit_res.status = ST_UNMATCHED_CLOSE;
                        end
                        after_eoe = 1'b1;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (slot_free) begin
                    if (count == CNT_W'(STACK_DEPTH)) begin
                        ctrl.clear      = 1'b1;
                        emit            = 1'b1;
                        emit_res.status = ST_OVERFLOW;
                    end else begin
                        ctrl.push = 1'b1;
                    end
                    after_eoe = 1'b1;
                end
            end
            S_FLUSH: begin
                if (slot_free) begin
                    if (count != '0 && top != CODE_OPEN) begin
                        emit        = 1'b1;
                        emit_res.ch = code_char(top);
                        emit_res.cv = 1'b1;
                        ctrl.pop    = 1'b1;
                    end else begin
                        if (count != '0) begin
                            ctrl.clear      = 1'b1;
                            emit            = 1'b1;
                            emit_res.status = ST_UNMATCHED_OPEN;
                        end
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    final_step = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (after_eoe) begin
            n_state = r_eoe ? S_FLUSH : S_FINISH;
        end
    end

    // a result waits in the pending slot until the next one shows whether it is last
    assign load_out = r_pend_v && (emit || final_step);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_pend_v <= 1'b1;
            end else if (final_step) begin
                r_pend_v <= 1'b0;
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_code <= n_code;
        r_eoe  <= n_eoe;
        if (emit) begin
            r_pend <= emit_res;
        end
        if (load_out) begin
            r_out      <= r_pend;
            r_out_last <= final_step;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.out_char    = r_out.ch;
    assign o_out.char_valid  = r_out.cv;
    assign o_out.status      = r_out.status;
    assign o_out.last_of_run = r_out_last;

    // checks
    `ASSERT_ALWAYS(a_count_range, count <= CNT_W'(STACK_DEPTH))
    `ASSERT_IMPLIES(a_idle_no_pend, r_state == S_IDLE, !r_pend_v)
    `ASSERT_NEXT(a_finish_to_idle, r_state == S_FINISH && slot_free, r_state == S_IDLE)
    `ASSERT_IMPLIES(a_status_no_char, r_out_v && r_out.status != ST_OK, !r_out.cv)

endmodule

FILE: tb/infix_to_postfix_converter_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the postfix stream and compares each result
module infix_to_postfix_converter_checker #(
    parameter int STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ifp_in_if    i_in_mon,
    ifp_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results_checked,
    output int   o_error_results
);
    import ifp_pkg::*;

    localparam int PRINT_LIMIT = 100;

    // printable character of each stacked arithmetic operator, indexed by code
    localparam logic [7:0] OP_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        t_status    status;
        logic       last_of_run;
    } t_postfix_item;

    t_postfix_item expected_postfix [$];
    t_postfix_item step_results [$];
    t_code         op_stack [STACK_DEPTH];
    int            op_level;

    initial begin
        o_fail_count      = 0;
        o_results_checked = 0;
        o_error_results   = 0;
        op_level          = 0;
    end

    function automatic void queue_result(input logic [7:0] ch, input logic cv,
                                         input t_status st);
        t_postfix_item r;
        r.out_char    = ch;
        r.char_valid  = cv;
        r.status      = st;
        r.last_of_run = 1'b0;
        step_results.push_back(r);
    endfunction

    // pop operators to the nearest open paren; high_only also stops at + and -
    function automatic void unwind_ops(input bit high_only);
        t_code top;
        while (op_level > 0) begin
            top = op_stack[op_level - 1];
            if (top == CODE_OPEN || (high_only && (top == CODE_ADD || top == CODE_SUB)))
                break;
            queue_result(OP_CHARS[top[1:0]], 1'b1, ST_OK);
            op_level--;
        end
    endfunction

    // push; a full stack drops the character and clears everything
    function automatic void stack_op(input t_code code);
        if (op_level >= STACK_DEPTH) begin
            op_level = 0;
            queue_result(8'h00, 1'b0, ST_OVERFLOW);
        end else begin
            op_stack[op_level] = code;
            op_level++;
        end
    endfunction

    function automatic void predict_postfix(input logic [7:0] ch, input logic eoe);
        step_results.delete();
        case (ch)
            CH_PLUS: begin
                unwind_ops(1'b0);
                stack_op(CODE_ADD);
            end
            CH_MINUS: begin
                unwind_ops(1'b0);
                stack_op(CODE_SUB);
            end
            CH_STAR: begin
                unwind_ops(1'b1);
                stack_op(CODE_MUL);
            end
            CH_SLASH: begin
                unwind_ops(1'b1);
                stack_op(CODE_DIV);
            end
            CH_OPEN: stack_op(CODE_OPEN);
            CH_CLOSE: begin
                unwind_ops(1'b0);
                if (op_level > 0)
                    op_level--;          // drop the matching open paren
                else
                    queue_result(8'h00, 1'b0, ST_UNMATCHED_CLOSE);
            end
            default: queue_result(ch, 1'b1, ST_OK);
        endcase
        // end mark: flush; an open paren left on the stack is an error
        if (eoe) begin
            unwind_ops(1'b0);
            if (op_level > 0) begin
                op_level = 0;
                queue_result(8'h00, 1'b0, ST_UNMATCHED_OPEN);
            end
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        foreach (step_results[i])
            expected_postfix.push_back(step_results[i]);
    endfunction

    // print stays bounded on a badly broken design, the count does not
    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      o_results_checked, field, got, want));
    endtask

    // outputs are compared before the new item is predicted: a result never leaves in the cycle its input is accepted
    always @(posedge i_clk) begin : monitor
        t_postfix_item want;
        if (!i_rst_n) begin
            op_level = 0;
            expected_postfix.delete();
            o_pending <= 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_postfix.size() == 0) begin
                    report_mismatch($sformatf("unexpected result char %0h status %0d",
                                              i_out_mon.out_char, i_out_mon.status));
                end else begin
                    want = expected_postfix.pop_front();
                    check_field("out_char", i_out_mon.out_char, want.out_char);
                    check_field("char_valid", i_out_mon.char_valid, want.char_valid);
                    check_field("status", i_out_mon.status, want.status);
                    check_field("last_of_run", i_out_mon.last_of_run, want.last_of_run);
                    if (want.status != ST_OK)
                        o_error_results++;
                    o_results_checked++;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_postfix(i_in_mon.in_char, i_in_mon.end_of_expression);
            o_pending <= expected_postfix.size();
        end
    end

endmodule

FILE: tb/infix_to_postfix_converter_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict; all checking lives in the checker instance
module infix_to_postfix_converter_tb;
    import ifp_pkg::*;

    localparam int ITEMS_TOTAL = 310;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 40;

    localparam logic [7:0] OPERATOR_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    localparam logic [7:0] SPECIAL_CHARS [6] =
        '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_OPEN, CH_CLOSE};

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;
    int results_checked;
    int error_results;
    int chars_sent;
    int expressions_sent;
    bit no_gaps;

    ifp_in_if  in_ch ();
    ifp_out_if out_ch ();

    infix_to_postfix_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    infix_to_postfix_converter_checker postfix_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_mon          (in_ch),
        .i_out_mon         (out_ch),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked),
        .o_error_results   (error_results)
    );

    always #1 i_clk = ~i_clk;

    // mostly back to back, sometimes short pauses, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit is_special(input logic [7:0] ch);
        return ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_OPEN, CH_CLOSE};
    endfunction

    function automatic logic [7:0] random_operand();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (is_special(ch));
        return ch;
    endfunction

    // one item; valid stays high on return so the next call can follow at once
    task automatic send_char(input logic [7:0] ch, input logic eoe = 1'b0);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.in_char           <= ch;
        in_ch.end_of_expression <= eoe;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        chars_sent++;
        if (eoe)
            expressions_sent++;
    endtask

    task automatic send_text(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_last && (i == s.len() - 1));
    endtask

    // hold the sender until every predicted result has been taken
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    // balanced expression with random operands, operators and nesting
    task automatic send_expression(input int max_depth, input int max_terms);
        logic [7:0] seq [$];
        int depth;
        int terms;
        depth = 0;
        terms = 0;
        do begin
            while (depth < max_depth && $urandom_range(0, 2) == 0) begin
                seq.push_back(CH_OPEN);
                depth++;
            end
            seq.push_back(random_operand());
            terms++;
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                seq.push_back(CH_CLOSE);
                depth--;
            end
            if (terms < max_terms)
                seq.push_back(OPERATOR_CHARS[$urandom_range(0, 3)]);
        end while (terms < max_terms);
        while (depth > 0) begin
            seq.push_back(CH_CLOSE);
            depth--;
        end
        foreach (seq[i])
            send_char(seq[i], i == seq.size() - 1);
    endtask

    // deep nesting around the stack limit, often not fully closed
    task automatic send_deep(input int opens);
        int closes;
        closes = $urandom_range(opens / 2, opens);
        repeat (opens) send_char(CH_OPEN);
        send_char(random_operand());
        send_char(OPERATOR_CHARS[$urandom_range(0, 3)]);
        send_char(random_operand());
        for (int i = 0; i < closes; i++)
            send_char(CH_CLOSE, i == closes - 1);
    endtask

    // arbitrary bytes, heavy on operators and parens, random end marks
    task automatic send_noise(input int count);
        logic [7:0] ch;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) == 1)
                ch = SPECIAL_CHARS[$urandom_range(0, 5)];
            else
                ch = 8'($urandom_range(0, 255));
            send_char(ch, $urandom_range(0, 3) == 0);
        end
    endtask

    // result side: random stalls, some long runs with ready held high
    initial begin : result_sink
        int r;
        int stall;
        int run;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 50)
                stall = 0;
            else if (r < 85)
                stall = $urandom_range(1, 3);
            else
                stall = $urandom_range(8, 40);
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
        end
    end

    // ends the run when neither side has moved an item for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int kind;
        i_rst_n                 <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.in_char           <= 8'h00;
        in_ch.end_of_expression <= 1'b0;
        no_gaps          = 1'b0;
        chars_sent       = 0;
        expressions_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: precedence, parens, operand extremes, unmatched open and close parens
        send_text("a+b*c/d-e", 1'b1);
        send_text("(a+b)*c", 1'b1);
        send_text("(x", 1'b1);        // open paren left at the end mark
        send_text(")", 1'b1);         // close paren on empty stack, with end mark
        send_char(8'h00);
        send_char(8'hFF, 1'b1);
        send_text("a-)", 1'b0);       // close pops the minus, then finds no paren
        wait_drained();

        // make sure the stack overflows at least once
        send_deep(17 + $urandom_range(0, 3));

        while (chars_sent < ITEMS_TOTAL) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            kind    = $urandom_range(0, 99);
            if (kind < 65)
                send_expression($urandom_range(1, 4), $urandom_range(1, 8));
            else if (kind < 75)
                send_deep($urandom_range(10, 20));
            else
                send_noise($urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters, %0d of them carrying an end mark.",
                 chars_sent, expressions_sent);
        $display("Checked %0d postfix results, %0d with an error status.",
                 results_checked, error_results);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
